// ===== hw/rtl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Holds request and status codes and the control state encoding.
// No dependencies; compile first.
package dq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DUMP       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_RDWAIT = 4'b0100,
    ST_DUMP   = 4'b1000
  } state_t;

  localparam int unsigned DATA_W = 32;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: ring buffer in a synchronous memory.
// Depends on dq_pkg (hw/rtl/dq_pkg.sv).
//
// Usage: requests arrive on the s_ channel as beats; s_tuser carries the
// action (push front, push back, pop front, pop back, dump) and s_tdata the
// signed value to push. Every request except an undefined action produces
// result beats on the m_ channel: m_tdata is the popped or dumped value
// (zero for push results and errors), m_tuser is the status (ok, empty,
// full) and m_tlast marks the final beat of the request.
// Timing: one request is worked on at a time. A push posts its result from
// the execute state; a pop posts the registered memory read data from the
// read-wait state; a dump streams one stored entry per cycle through the
// single memory read port while the receiver takes them. An empty dump or a
// failed push or pop answers from the execute state. The next request
// is accepted once the prior one's last result is in the output register.
// Reset clears the front index and the occupancy, so the queue is empty;
// the entry memory itself is not cleared, because only occupied entries
// are ever read. When the receiver stalls, the result waits in the output
// register and the block holds further work until that register drains.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [2:0]               s_tuser,   // [2:0] action
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic signed [DATA_W-1:0] m_tdata,   // [31:0] result_value
  output logic [1:0]               m_tuser,   // [1:0] status
  output logic                     m_tlast
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_S  = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

  // Add two slot offsets and wrap modulo DEPTH; the sum stays below 2*DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  // Control and queue pointers.
  state_t                state, state_next;
  logic [IDX_W-1:0]      front_index, front_index_next;
  logic [OCC_W-1:0]      occupancy, occupancy_next;
  logic [IDX_W-1:0]      dump_slot, dump_slot_next;
  logic [OCC_W-1:0]      dump_left, dump_left_next;

  // Held request.
  action_t               action;
  logic [DATA_W-1:0]     value;

  // Entry memory ports.
  logic [DATA_W-1:0]     mem [DEPTH];
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [DATA_W-1:0]     rd_data;

  // Output register load.
  logic                  out_free;
  logic                  load_out;
  logic [DATA_W-1:0]     out_data;
  status_t               out_status;
  logic                  out_last;

  logic                  is_full, is_empty;
  logic [OCC_W-1:0]      occ_m1;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign is_full  = (occupancy == OCC_FULL);
  assign is_empty = (occupancy == '0);
  assign occ_m1   = occupancy - OCC_ONE;

  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    occupancy_next   = occupancy;
    dump_slot_next   = dump_slot;
    dump_left_next   = dump_left;
    wr_en            = 1'b0;
    wr_addr          = front_index;
    rd_en            = 1'b0;
    rd_addr          = front_index;
    load_out         = 1'b0;
    out_data         = '0;
    out_status       = STATUS_OK;
    out_last         = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // Every defined action either posts a result now or starts a read,
        // so wait here until the output register can take a beat.
        if (action != ACT_PUSH_FRONT && action != ACT_PUSH_BACK &&
            action != ACT_POP_FRONT && action != ACT_POP_BACK &&
            action != ACT_DUMP) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          priority if (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
            if (is_full) begin
              out_status = STATUS_FULL;
            end else begin
              wr_en          = 1'b1;
              occupancy_next = occupancy + OCC_ONE;
              if (action == ACT_PUSH_FRONT) begin
                front_index_next = (front_index == '0) ? LAST_IDX
                                                       : front_index - IDX_ONE;
                wr_addr          = front_index_next;
              end else begin
                wr_addr = wrap_add(front_index, occupancy[IDX_W-1:0]);
              end
            end
          end else if (is_empty) begin
            // Pop or dump on an empty queue.
            load_out   = 1'b1;
            out_status = STATUS_EMPTY;
            state_next = ST_IDLE;
          end else if (action == ACT_DUMP) begin
            rd_en          = 1'b1;
            rd_addr        = front_index;
            dump_slot_next = wrap_add(front_index, IDX_ONE);
            dump_left_next = occ_m1;
            state_next     = ST_DUMP;
          end else begin
            rd_en          = 1'b1;
            occupancy_next = occ_m1;
            state_next     = ST_RDWAIT;
            if (action == ACT_POP_FRONT) begin
              rd_addr          = front_index;
              front_index_next = wrap_add(front_index, IDX_ONE);
            end else begin
              rd_addr = wrap_add(front_index, occ_m1[IDX_W-1:0]);
            end
          end
        end
      end

      ST_RDWAIT: begin
        // Read data stays put until the next read, so it can wait for space.
        if (out_free) begin
          load_out   = 1'b1;
          out_data   = rd_data;
          state_next = ST_IDLE;
        end
      end

      ST_DUMP: begin
        if (out_free) begin
          load_out = 1'b1;
          out_data = rd_data;
          out_last = (dump_left == '0);
          if (dump_left == '0) begin
            state_next = ST_IDLE;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = dump_slot;
            dump_slot_next = wrap_add(dump_slot, IDX_ONE);
            dump_left_next = dump_left - OCC_ONE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      dump_slot   <= '0;
      dump_left   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      occupancy   <= occupancy_next;
      dump_slot   <= dump_slot_next;
      dump_left   <= dump_left_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request capture and output payload need no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      action <= action_t'(s_tuser);
      value  <= s_tdata;
    end
    if (load_out) begin
      m_tdata <= out_data;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Occupancy never exceeds the capacity of the ring.
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_FULL)
    else $error("occupancy above capacity");

  // The front index always names a slot that exists.
  a_front_range: assert property (@(posedge clk) disable iff (rst)
    front_index <= LAST_IDX)
    else $error("front index out of range");

  // A successful push grows the queue by exactly one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en) |=> (occupancy == $past(occupancy) + OCC_ONE))
    else $error("push did not grow occupancy by one");

  // A dump never changes the stored queue.
  a_dump_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> ($stable(occupancy) && $stable(front_index)))
    else $error("dump modified the queue");

  // A result is only loaded when the output register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) || !load_out))
    else $error("pending result overwritten");

endmodule
